// ----- rtl/adaptive_relaxation_factor_defines.svh -----
// Assertion macros for the relaxation factor block.
`ifndef ADAPTIVE_RELAXATION_FACTOR_DEFINES_SVH
`define ADAPTIVE_RELAXATION_FACTOR_DEFINES_SVH
// Implication checked on every edge outside reset.
`define ARF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ARF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/arf_pkg.sv -----
// Shared types and constants of the relaxation factor block.
package arf_pkg;
    localparam int FW = 18;
    localparam int RW = 64;
    localparam int HISTORY_DEPTH_DEF = 4;
    localparam logic [FW-1:0] INITIAL_FACTOR_DEF = 18'd32768;
    localparam logic [FW-1:0] CAP_EARLY = 18'd19661;
    localparam logic [FW-1:0] CAP_POOR = 18'd6554;
    localparam logic [RW-1:0] POOR_RESIDUAL = 64'd100 << 40;
    localparam logic [15:0] RUN_MAX = 16'hFFFF;

    localparam logic [2:0] KIND_FIRST = 3'd0;
    localparam logic [2:0] KIND_OSC = 3'd1;
    localparam logic [2:0] KIND_DIV = 3'd2;
    localparam logic [2:0] KIND_MOD = 3'd3;
    localparam logic [2:0] KIND_EXC = 3'd4;
    localparam logic [2:0] KIND_NONE = 3'd5;

    localparam logic [2:0] REG_OSC_GAIN = 3'd0;
    localparam logic [2:0] REG_DIV_RATIO = 3'd1;
    localparam logic [2:0] REG_DEC_GAIN = 3'd2;
    localparam logic [2:0] REG_EXC_RATIO = 3'd3;
    localparam logic [2:0] REG_MOD_GAIN = 3'd4;
    localparam logic [2:0] REG_STR_GAIN = 3'd5;
    localparam logic [2:0] REG_CEIL = 3'd6;
    localparam logic [2:0] REG_FLOOR = 3'd7;

    // datapath operation selected by the controller
    typedef enum logic [2:0] {
        OP_IDLE   = 3'd0,
        OP_LOAD   = 3'd1,  // capture request, push window
        OP_OSC    = 3'd2,  // window sum and sign changes
        OP_RATIO1 = 3'd3,  // compare against divergence ratio
        OP_RATIO2 = 3'd4,  // compare against excellent ratio
        OP_SCALE  = 3'd5,  // factor times gain, registered
        OP_FINISH = 3'd6   // clamp, caps, runs, commit
    } op_t;

    typedef struct packed {
        op_t  op;
        logic mul_step;  // one 32-bit slice of the ratio product
        logic [1:0] slice;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic osc;
        logic zero_zero;
    } status_t;
endpackage

// ----- rtl/arf_ctrl.sv -----
// Controller sequencing the relaxation factor datapath.
module arf_ctrl
    import arf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_OSC   = 8'b00000010,
        S_R1    = 8'b00000100,
        S_R2    = 8'b00001000,
        S_SCALE = 8'b00010000,
        S_FIN   = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_LOAD  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] slice_reg, slice_next;
    logic out_valid_reg, out_valid_next;

    // a new request is taken once the previous result has left
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        slice_next = slice_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op = OP_IDLE;
        cmd.mul_step = 1'b0;
        cmd.slice = slice_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (status.first)
                begin
                    cmd.op = OP_FINISH;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op = OP_OSC;
                    state_next = S_OSC;
                end
            end
            S_OSC:
            begin
                slice_next = 2'd0;
                if (status.osc || status.zero_zero)
                    state_next = S_SCALE;
                else
                    state_next = S_R1;
            end
            S_R1:
            begin
                cmd.op = OP_RATIO1;
                cmd.mul_step = 1'b1;
                slice_next = slice_reg + 2'd1;
                if (slice_reg == 2'd1)
                begin
                    slice_next = 2'd0;
                    state_next = S_R2;
                end
            end
            S_R2:
            begin
                cmd.op = OP_RATIO2;
                cmd.mul_step = 1'b1;
                slice_next = slice_reg + 2'd1;
                if (slice_reg == 2'd1)
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.op = OP_SCALE;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op = OP_FINISH;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slice_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slice_reg <= slice_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ----- rtl/arf_datapath.sv -----
// Datapath: window, ratio compares, gain multiply, clamps and run counters.
module arf_datapath
    import arf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter logic [FW-1:0] INITIAL_FACTOR = INITIAL_FACTOR_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          cmd,
    output status_t       status,
    input  logic [RW-1:0] residual,
    input  logic [15:0]   iteration,
    input  logic          cfg_valid,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    output logic [FW-1:0] relaxation_factor,
    output logic [2:0]    adjustment_kind,
    output logic [15:0]   improvement_run,
    output logic [15:0]   deterioration_run
);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic [FW-1:0] osc_gain_reg, dec_gain_reg, mod_gain_reg, str_gain_reg;
    logic [FW-1:0] ceil_reg, floor_reg;
    logic [23:0] div_ratio_reg, exc_ratio_reg;

    logic [RW-1:0] win_reg [HISTORY_DEPTH];
    logic [CW-1:0] fill_reg;
    logic [RW-1:0] last_reg, cur_reg;
    logic [15:0] iter_reg;
    logic first_reg;
    logic [FW-1:0] factor_reg;
    logic [15:0] good_reg, bad_reg;
    logic [2:0] kind_reg;
    logic osc_reg;
    logic div_reg, exc_reg;
    logic [88:0] prod_reg;  // prev * ratio, built from two 32-bit slices
    logic [35:0] scaled_reg;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osc_gain_reg <= 18'd32768;
            div_ratio_reg <= 24'd65536;
            dec_gain_reg <= 18'd32768;
            exc_ratio_reg <= 24'd32768;
            mod_gain_reg <= 18'd68813;
            str_gain_reg <= 18'd78643;
            ceil_reg <= 18'd65536;
            floor_reg <= 18'd655;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OSC_GAIN:  osc_gain_reg <= cfg_data[FW-1:0];
                REG_DIV_RATIO: div_ratio_reg <= cfg_data;
                REG_DEC_GAIN:  dec_gain_reg <= cfg_data[FW-1:0];
                REG_EXC_RATIO: exc_ratio_reg <= cfg_data;
                REG_MOD_GAIN:  mod_gain_reg <= cfg_data[FW-1:0];
                REG_STR_GAIN:  str_gain_reg <= cfg_data[FW-1:0];
                REG_CEIL:      ceil_reg <= cfg_data[FW-1:0];
                REG_FLOOR:     floor_reg <= cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // ---- oscillation over newest four entries ----
    logic [RW-1:0] w0, w1, w2, w3;
    logic [RW+1:0] wsum;
    logic p0, p1, p2, p3;
    logic [1:0] changes;
    always_comb
    begin
        w0 = win_reg[HISTORY_DEPTH-4];
        w1 = win_reg[HISTORY_DEPTH-3];
        w2 = win_reg[HISTORY_DEPTH-2];
        w3 = win_reg[HISTORY_DEPTH-1];
        wsum = {2'b00, w0} + {2'b00, w1} + {2'b00, w2} + {2'b00, w3};
        p0 = {w0, 2'b00} > wsum;
        p1 = {w1, 2'b00} > wsum;
        p2 = {w2, 2'b00} > wsum;
        p3 = {w3, 2'b00} > wsum;
        changes = {1'b0, p0 ^ p1} + {1'b0, p1 ^ p2} + {1'b0, p2 ^ p3};
    end

    // ---- ratio product, 32-bit slice of prev per step ----
    logic [RW-1:0] prev_sel;
    logic [23:0] ratio_sel;
    logic [55:0] part;
    logic [88:0] prod_acc;
    logic [79:0] num;
    logic ratio_gt, ratio_lt;
    always_comb
    begin
        ratio_sel = (cmd.op == OP_RATIO1) ? div_ratio_reg : exc_ratio_reg;
        prev_sel = last_reg;
        part = (cmd.slice[0] ? prev_sel[63:32] : prev_sel[31:0]) * ratio_sel;
        prod_acc = cmd.slice[0] ? (prod_reg + {1'b0, part, 32'd0})
                                : {33'd0, part};
        num = {cur_reg, 16'd0};
        ratio_gt = {9'd0, num} > prod_acc;
        ratio_lt = {9'd0, num} < prod_acc;
    end

    // ---- gain select ----
    logic [FW-1:0] gain_sel;
    always_comb
    begin
        if (osc_reg)
            gain_sel = osc_gain_reg;
        else if (div_reg)
            gain_sel = dec_gain_reg;
        else if (exc_reg)
            gain_sel = str_gain_reg;
        else
            gain_sel = mod_gain_reg;
    end

    // ---- finishing: clamp, caps ----
    // scaled factor keeps two bits above Q2.16 until the clamps bring it back
    logic [FW+1:0] f_sc, f_cl;
    logic zz;
    always_comb
    begin
        zz = (cur_reg == '0) && (last_reg == '0);
        f_sc = zz && !osc_reg ? {2'b00, factor_reg} : scaled_reg[35:16];
        if (!osc_reg && !zz && !div_reg && f_sc > {2'b00, ceil_reg})
            f_sc = {2'b00, ceil_reg};
        f_cl = f_sc;
        if (f_cl < {2'b00, floor_reg})
            f_cl = {2'b00, floor_reg};
        else if (f_cl > {2'b00, ceil_reg})
            f_cl = {2'b00, ceil_reg};
        if (iter_reg < 16'd5 && f_cl > {2'b00, CAP_EARLY})
            f_cl = {2'b00, CAP_EARLY};
        if (cur_reg > POOR_RESIDUAL && f_cl > {2'b00, CAP_POOR})
            f_cl = {2'b00, CAP_POOR};
    end

    assign status.first = first_reg;
    assign status.osc = (fill_reg >= CW'(4)) && (changes >= 2'd2);
    assign status.zero_zero = zz;

    // Window shifts toward index 0; the newest entry always sits at the top.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            cur_reg <= residual;
            iter_reg <= iteration;
            for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[HISTORY_DEPTH-1] <= residual;
        end
        if (cmd.mul_step)
            prod_reg <= prod_acc;
        if (cmd.op == OP_SCALE)
            scaled_reg <= factor_reg * gain_sel;
    end

    // Once four entries are held, the top four are the newest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            last_reg <= '0;
            first_reg <= 1'b1;
            factor_reg <= INITIAL_FACTOR;
            good_reg <= '0;
            bad_reg <= '0;
            kind_reg <= KIND_FIRST;
            osc_reg <= 1'b0;
            div_reg <= 1'b0;
            exc_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    if (fill_reg < CW'(HISTORY_DEPTH))
                        fill_reg <= fill_reg + CW'(1);
                    osc_reg <= 1'b0;
                    div_reg <= 1'b0;
                    exc_reg <= 1'b0;
                end
                OP_OSC: osc_reg <= status.osc;
                OP_RATIO1: if (cmd.slice[0]) div_reg <= ratio_gt;
                OP_RATIO2: if (cmd.slice[0]) exc_reg <= ratio_lt;
                OP_FINISH:
                begin
                    last_reg <= cur_reg;
                    if (first_reg)
                    begin
                        first_reg <= 1'b0;
                        kind_reg <= KIND_FIRST;
                    end
                    else
                    begin
                        factor_reg <= f_cl[FW-1:0];
                        if (osc_reg)
                        begin
                            good_reg <= '0;
                            bad_reg <= '0;
                            kind_reg <= KIND_OSC;
                        end
                        else if (zz)
                            kind_reg <= KIND_NONE;
                        else if (div_reg)
                        begin
                            if (bad_reg != RUN_MAX) bad_reg <= bad_reg + 16'd1;
                            good_reg <= '0;
                            kind_reg <= KIND_DIV;
                        end
                        else
                        begin
                            if (good_reg != RUN_MAX) good_reg <= good_reg + 16'd1;
                            bad_reg <= '0;
                            kind_reg <= exc_reg ? KIND_EXC : KIND_MOD;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign relaxation_factor = factor_reg;
    assign adjustment_kind = kind_reg;
    assign improvement_run = good_reg;
    assign deterioration_run = bad_reg;
endmodule

// ----- rtl/adaptive_relaxation_factor.sv -----
// Top level of the adaptive relaxation factor controller.
// Steps: load and finish for the first request; otherwise load, oscillation check,
// the two ratio compares (skipped on oscillation or zero over zero), scale, finish.
// A request is taken only when idle; a held result stalls the input.
// The ratio compares use a 32x24 multiplier twice per threshold, then one 18x18
// gain multiply. Reset (rst_n, async, low): registers take their reset values,
// factor takes INITIAL_FACTOR, the next request is treated as the first.
`include "adaptive_relaxation_factor_defines.svh"
module adaptive_relaxation_factor
    import arf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter logic [FW-1:0] INITIAL_FACTOR = INITIAL_FACTOR_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [RW-1:0] residual,
    input  logic [15:0]   iteration,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [FW-1:0] relaxation_factor,
    output logic [2:0]    adjustment_kind,
    output logic [15:0]   improvement_run,
    output logic [15:0]   deterioration_run,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data
);
    cmd_t cmd;
    status_t status;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    arf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .cmd(cmd)
    );

    arf_datapath #(
        .HISTORY_DEPTH(HISTORY_DEPTH), .INITIAL_FACTOR(INITIAL_FACTOR)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .residual(residual), .iteration(iteration),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .relaxation_factor(relaxation_factor), .adjustment_kind(adjustment_kind),
        .improvement_run(improvement_run), .deterioration_run(deterioration_run)
    );

    // a request is never taken while a result waits
    `ARF_ASSERT_IMP(a_no_accept_busy, out_valid && out_stall, in_stall)
    // result holds while stalled
    `ARF_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(relaxation_factor))
    // kind code stays within its range
    `ARF_ASSERT_IMP(a_kind, out_valid, adjustment_kind <= KIND_NONE)
endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the adaptive relaxation factor controller.
import arf_pkg::*;

typedef struct packed {
    logic [FW-1:0] factor;
    logic [2:0]    kind;
    logic [15:0]   good;
    logic [15:0]   bad;
} factor_result_t;

// Predicts the factor update of each request and checks the block's results.
class relaxation_predictor;
    localparam int EARLY_ITERS = 5;
    logic [23:0]     cfg[8];
    logic [RW-1:0]   window[4];
    int              fill;
    logic [RW-1:0]   last_res;
    bit              first;
    logic [FW-1:0]   factor;
    logic [15:0]     good_run, bad_run;
    factor_result_t  expected_factors[$];
    int              errors, results, requests;
    int              kind_seen[6];

    function new();
        cfg[REG_OSC_GAIN]  = 24'd32768;
        cfg[REG_DIV_RATIO] = 24'd65536;
        cfg[REG_DEC_GAIN]  = 24'd32768;
        cfg[REG_EXC_RATIO] = 24'd32768;
        cfg[REG_MOD_GAIN]  = 24'd68813;
        cfg[REG_STR_GAIN]  = 24'd78643;
        cfg[REG_CEIL]      = 24'd65536;
        cfg[REG_FLOOR]     = 24'd655;
        fill = 0;
        last_res = '0;
        first = 1'b1;
        factor = INITIAL_FACTOR_DEF;
        good_run = '0;
        bad_run = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] d);
        if (idx == REG_DIV_RATIO || idx == REG_EXC_RATIO)
            cfg[idx] = d;
        else
            cfg[idx] = {6'd0, d[17:0]};
    endfunction

    // exact sign of cur/prev - t/2^16
    function int ratio_sign(logic [RW-1:0] cur, logic [RW-1:0] prev, logic [23:0] t);
        logic [95:0] a, b;
        a = {16'd0, cur, 16'd0};
        b = 96'(prev) * 96'(t);
        return (a > b) ? 1 : ((a < b) ? -1 : 0);
    endfunction

    // two or more sign flips of deviation from the window mean
    function bit swings();
        logic [65:0] sum;
        int changes;
        bit pos, prev_pos;
        if (fill < 4) return 1'b0;
        sum = '0;
        changes = 0;
        prev_pos = 1'b0;
        for (int i = 0; i < 4; i++) sum += 66'(window[i]);
        for (int i = 0; i < 4; i++)
        begin
            pos = {window[i], 2'b00} > sum;
            if (i > 0 && pos != prev_pos) changes++;
            prev_pos = pos;
        end
        return changes >= 2;
    endfunction

    function logic [19:0] scale(logic [FW-1:0] f, logic [23:0] g);
        logic [43:0] p;
        p = 44'(f) * 44'(g);
        return p[35:16];
    endfunction

    function void push(logic [RW-1:0] r);
        if (fill < 4)
        begin
            window[fill] = r;
            fill++;
        end
        else
        begin
            for (int i = 0; i < 3; i++) window[i] = window[i + 1];
            window[3] = r;
        end
    endfunction

    function void note_request(logic [RW-1:0] cur, logic [15:0] it);
        logic [19:0] f;
        logic [2:0] kind;
        bit use_strong;
        factor_result_t res;
        requests++;
        f = 20'(factor);
        push(cur);
        if (first)
        begin
            first = 1'b0;
            kind = KIND_FIRST;
        end
        else
        begin
            if (swings())
            begin
                f = scale(factor, cfg[REG_OSC_GAIN]);
                good_run = '0;
                bad_run = '0;
                kind = KIND_OSC;
            end
            else if (cur == 0 && last_res == 0)
                kind = KIND_NONE;
            else if (ratio_sign(cur, last_res, cfg[REG_DIV_RATIO]) > 0)
            begin
                if (bad_run != RUN_MAX) bad_run++;
                good_run = '0;
                f = scale(factor, cfg[REG_DEC_GAIN]);
                kind = KIND_DIV;
            end
            else
            begin
                use_strong = ratio_sign(cur, last_res, cfg[REG_EXC_RATIO]) < 0;
                if (good_run != RUN_MAX) good_run++;
                bad_run = '0;
                f = scale(factor, use_strong ? cfg[REG_STR_GAIN] : cfg[REG_MOD_GAIN]);
                if (f > 20'(cfg[REG_CEIL])) f = 20'(cfg[REG_CEIL]);
                kind = use_strong ? KIND_EXC : KIND_MOD;
            end
            if (f < 20'(cfg[REG_FLOOR])) f = 20'(cfg[REG_FLOOR]);
            else if (f > 20'(cfg[REG_CEIL])) f = 20'(cfg[REG_CEIL]);
            if (it < EARLY_ITERS && f > 20'(CAP_EARLY)) f = 20'(CAP_EARLY);
            if (cur > POOR_RESIDUAL && f > 20'(CAP_POOR)) f = 20'(CAP_POOR);
            factor = f[FW-1:0];
        end
        last_res = cur;
        res.factor = factor;
        res.kind = kind;
        res.good = good_run;
        res.bad = bad_run;
        expected_factors = {expected_factors, res};
    endfunction

    function void check_result(logic [FW-1:0] f, logic [2:0] k, logic [15:0] g,
                               logic [15:0] b);
        factor_result_t e;
        results++;
        if (expected_factors.size() == 0)
        begin
            $error("result with no request pending");
            errors++;
            return;
        end
        e = expected_factors.pop_front();
        if (e.kind <= KIND_NONE) kind_seen[e.kind]++;
        if (f !== e.factor)
        begin
            $error("relaxation_factor: expected %0d, got %0d", e.factor, f);
            errors++;
        end
        if (k !== e.kind)
        begin
            $error("adjustment_kind: expected %0d, got %0d", e.kind, k);
            errors++;
        end
        if (g !== e.good)
        begin
            $error("improvement_run: expected %0d, got %0d", e.good, g);
            errors++;
        end
        if (b !== e.bad)
        begin
            $error("deterioration_run: expected %0d, got %0d", e.bad, b);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int RANDOM_ITEMS = 1630;
    localparam int HOLD_CYCLES = 400;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [RW-1:0] residual = '0;
    logic [15:0]   iteration = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [FW-1:0] relaxation_factor;
    logic [2:0]    adjustment_kind;
    logic [15:0]   improvement_run;
    logic [15:0]   deterioration_run;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [23:0]   cfg_data = '0;

    relaxation_predictor pred = new();
    int  cycles = 0;
    bit  hold_req = 1'b0;    // asks the result side for one long hold-off
    bit  hold_done = 1'b0;
    logic [RW-1:0] level;    // running residual of the synthetic solver
    logic [15:0]   iter_now;

    adaptive_relaxation_factor u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .residual          (residual),
        .iteration         (iteration),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .relaxation_factor (relaxation_factor),
        .adjustment_kind   (adjustment_kind),
        .improvement_run   (improvement_run),
        .deterioration_run (deterioration_run),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result monitor: values read here are the ones held before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            pred.check_result(relaxation_factor, adjustment_kind, improvement_run,
                              deterioration_run);
    end

    // Result-side backpressure: random stall stretches, free stretches, and one
    // long hold-off on request so the block backs up into its input.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            n = $urandom_range(0, 99);
            out_stall <= (n < 60) ? 1'b0 : 1'b1;
            if (n < 15)      repeat ($urandom_range(30, 120)) @(posedge clk);
            else if (n < 60) repeat ($urandom_range(1, 8)) @(posedge clk);
            else if (n < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
            else             repeat ($urandom_range(20, 60)) @(posedge clk);
        end
    end

    // Offer one request and hold it until accepted. Valid stays high into the
    // next request when the random gap is zero; pause forces a gap.
    task automatic send_request(logic [RW-1:0] r, logic [15:0] it, bit pause = 1'b0);
        int g, gap;
        residual <= r;
        iteration <= it;
        if (!in_valid) in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        pred.note_request(r, it);
        g = $urandom_range(0, 99);
        if (g < 50)      gap = 0;
        else if (g < 85) gap = $urandom_range(1, 3);
        else if (g < 97) gap = $urandom_range(4, 10);
        else             gap = $urandom_range(20, 60);
        if (pause && gap == 0) gap = 1;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait until every expected result is back, then cover the block's latency.
    task automatic drain();
        while (pred.expected_factors.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_config(logic [23:0] vals[8]);
        for (logic [3:0] i = REG_OSC_GAIN; i <= REG_FLOOR; i++)
        begin
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            pred.write_reg(i[2:0], vals[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Next residual of a synthetic solver; the mode shapes the sequence.
    function automatic logic [RW-1:0] next_residual(int mode, int step);
        logic [79:0] p;
        case (mode)
            0:  p = 80'(level) * $urandom_range(90, 255);    // converging
            1:  p = 80'(level) * $urandom_range(257, 700);   // diverging
            2:  p = 80'(level) * ((step % 2) ? 40 : 900);    // oscillating
            3:  p = 80'(level) * $urandom_range(200, 320);   // near unity
            default: p = {16'd0, $urandom, $urandom};
        endcase
        if (mode < 4) p = p >> 8;
        if (p[79:64] != 0) p = 80'(64'hFFFF_FFFF_FFFF_FFFF);
        if (mode < 4 && p == 0) p = 80'($urandom_range(1, 1000));
        return p[RW-1:0];
    endfunction

    task automatic random_items(int count);
        int mode, run, n;
        logic [RW-1:0] r;
        logic [15:0] it;
        mode = 0;
        run = 0;
        for (int k = 0; k < count; k++)
        begin
            if (run == 0)
            begin
                n = $urandom_range(0, 99);
                mode = (n < 30) ? 0 : (n < 50) ? 1 : (n < 65) ? 2 : (n < 85) ? 3 : 4;
                run = $urandom_range(4, 20);
                if ($urandom_range(0, 3) == 0)
                    level = 64'($urandom) << $urandom_range(0, 30);
            end
            run--;
            n = $urandom_range(0, 99);
            if (n < 3)       r = '0;
            else if (n < 6)  r = POOR_RESIDUAL + $urandom_range(0, 1);
            else             r = next_residual(mode, k);
            level = r;
            if ($urandom_range(0, 9) == 0) it = 16'($urandom);
            else
            begin
                iter_now++;
                it = iter_now;
            end
            if (k == count / 2) hold_req = 1'b1;
            send_request(r, it);
        end
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [23:0] vals[8];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first request, zero over zero, zero previous, early and
        // poor caps, residual extremes, oscillation, cap threshold.
        send_request(64'd0, 16'd0);
        send_request(64'd0, 16'd1);
        send_request(64'd5 << 40, 16'd2);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_request(64'd1 << 40, 16'd7);
        send_request(64'd15 << 36, 16'd8);
        send_request(64'd14 << 36, 16'd9);
        send_request(64'd20 << 36, 16'd10);
        send_request(64'd2 << 36, 16'd11);
        send_request(64'd20 << 36, 16'd12);
        send_request(64'd2 << 36, 16'd13);
        send_request(POOR_RESIDUAL, 16'd14);
        send_request(POOR_RESIDUAL + 1, 16'd15);
        send_request(64'd1, 16'd4);
        send_request(64'd1, 16'd5);
        send_request(64'd0, 16'd16, 1'b1);
        drain();

        // Phase 1: reset configuration; the long result hold-off lands here.
        level = 64'd1 << 40;
        iter_now = '0;
        random_items(RANDOM_ITEMS / 5);
        drain();

        // Phase 2: random configuration.
        for (int i = 0; i < 8; i++) vals[i] = 24'($urandom);
        vals[REG_CEIL] = 24'($urandom_range(20000, 200000));
        vals[REG_FLOOR] = 24'($urandom_range(0, 20000));
        write_config(vals);
        iter_now = '0;
        random_items(RANDOM_ITEMS / 5);
        drain();

        // Phase 3: every register at zero.
        for (int i = 0; i < 8; i++) vals[i] = '0;
        write_config(vals);
        iter_now = '0;
        random_items(RANDOM_ITEMS / 5);
        drain();

        // Phase 4: every register at its maximum.
        for (int i = 0; i < 8; i++) vals[i] = 24'hFF_FFFF;
        write_config(vals);
        iter_now = '0;
        random_items(RANDOM_ITEMS / 5);
        drain();

        // Phase 5: floor above ceiling, mid-range gains and ratios.
        vals[REG_OSC_GAIN]  = 24'd40000;
        vals[REG_DIV_RATIO] = 24'd70000;
        vals[REG_DEC_GAIN]  = 24'd50000;
        vals[REG_EXC_RATIO] = 24'd30000;
        vals[REG_MOD_GAIN]  = 24'd70000;
        vals[REG_STR_GAIN]  = 24'd90000;
        vals[REG_CEIL]      = 24'd3000;
        vals[REG_FLOOR]     = 24'd50000;
        write_config(vals);
        iter_now = '0;
        random_items(RANDOM_ITEMS - 4 * (RANDOM_ITEMS / 5));

        drain();
        $display("Covered %0d requests, %0d results over five register settings.",
                 pred.requests, pred.results);
        $display("Kinds first/osc/diverge/moderate/excellent/none: %0d %0d %0d %0d %0d %0d",
                 pred.kind_seen[KIND_FIRST], pred.kind_seen[KIND_OSC],
                 pred.kind_seen[KIND_DIV], pred.kind_seen[KIND_MOD],
                 pred.kind_seen[KIND_EXC], pred.kind_seen[KIND_NONE]);
        if (pred.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
